[rtl/pac_pkg.sv]
// Package with the shared types, codes and reset values of the proximity alert classifier.
package pac_pkg;

    typedef enum logic [1:0] {
        STATUS_VALID     = 2'd0,
        STATUS_READ_ERR  = 2'd1,
        STATUS_OUT_RANGE = 2'd2,
        STATUS_HELD      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        REG_NEAR_THRESHOLD = 3'd0,
        REG_FALL_LOW       = 3'd1,
        REG_MAX_RANGE      = 3'd2,
        REG_QUIET_PERIOD   = 3'd3,
        REG_DWELL_PERIOD   = 3'd4
    } reg_index_t;

    localparam int unsigned DIST_W = 16;
    localparam int unsigned TICK_W = 32;
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    localparam logic [DIST_W-1:0] READ_ERROR_CODE     = 16'hFFFF;
    localparam logic [DIST_W-1:0] NEAR_THRESHOLD_RST  = 16'd200;
    localparam logic [DIST_W-1:0] FALL_LOW_RST        = 16'd100;
    localparam logic [DIST_W-1:0] MAX_RANGE_RST       = 16'd2000;
    localparam logic [TICK_W-1:0] QUIET_PERIOD_RST    = 32'd5000;
    localparam logic [TICK_W-1:0] DWELL_PERIOD_RST    = 32'd5000;

    // True when at least period ticks have passed since the mark, modulo 2^32.
    function automatic logic elapsed(input logic [TICK_W-1:0] now,
                                     input logic [TICK_W-1:0] since,
                                     input logic [TICK_W-1:0] period);
        logic [TICK_W-1:0] diff;
        diff = now - since;
        return diff >= period;
    endfunction

endpackage

[rtl/proximity_alert_classifier.sv]
// Proximity alert classifier: sample classification, connection tracking and alerts.
// A sample is taken into the input register, and its result is held in the result register.
// Throughput: one sample per cycle while out_stall is low; the state update for a sample is
// computed combinationally between the input register and the result register, so samples follow back to back.
// Reset (rst_n low, asynchronous) empties both stages, restores the register defaults
// and clears the tracking state, with the sensor marked as connected.
module proximity_alert_classifier (
    input  logic                           clk,
    input  logic                           rst_n,
    // sample input
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [pac_pkg::DIST_W-1:0]     distance_mm,
    input  logic [pac_pkg::TICK_W-1:0]     now_ticks,
    input  logic                           emergency_hold,
    // result output
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     sample_status,
    output logic [pac_pkg::DIST_W-1:0]     valid_distance,
    output logic                           disconnect_event,
    output logic                           reconnect_event,
    output logic                           range_report,
    output logic                           near_alert,
    output logic                           dwell_alert,
    output logic                           fall_alert,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pac_pkg::ADDR_W-1:0]     paddr,
    input  logic [pac_pkg::DATA_W-1:0]     pwdata,
    output logic [pac_pkg::DATA_W-1:0]     prdata,
    output logic                           pready
);

    // Configuration registers
    logic [pac_pkg::DIST_W-1:0] near_thr_reg;
    logic [pac_pkg::DIST_W-1:0] fall_low_reg;
    logic [pac_pkg::DIST_W-1:0] max_range_reg;
    logic [pac_pkg::TICK_W-1:0] quiet_reg;
    logic [pac_pkg::TICK_W-1:0] dwell_reg;

    // Input stage
    logic                       s1_valid_reg;
    logic [pac_pkg::DIST_W-1:0] s1_dist_reg;
    logic [pac_pkg::TICK_W-1:0] s1_now_reg;
    logic                       s1_hold_reg;

    // Tracking state
    logic [pac_pkg::DIST_W-1:0] prev_dist_reg,       prev_dist_next;
    logic                       connected_reg,       connected_next;
    logic [pac_pkg::TICK_W-1:0] last_range_reg,      last_range_next;
    logic [pac_pkg::TICK_W-1:0] near_start_reg,      near_start_next;
    logic                       obj_near_reg,        obj_near_next;
    logic                       dwell_done_reg,      dwell_done_next;
    logic [pac_pkg::TICK_W-1:0] last_near_reg,       last_near_next;
    logic [pac_pkg::TICK_W-1:0] last_fall_reg,       last_fall_next;

    // Result register
    logic                       out_valid_reg;
    pac_pkg::status_t           status_reg,          status_next;
    logic [pac_pkg::DIST_W-1:0] vdist_reg,           vdist_next;
    logic                       disc_reg,            disc_next;
    logic                       reco_reg,            reco_next;
    logic                       range_reg,           range_next;
    logic                       near_reg,            near_next;
    logic                       dwell_reg_o,         dwell_next;
    logic                       fall_reg,            fall_next;

    logic                       advance;
    logic                       cfg_write;
    pac_pkg::reg_index_t        cfg_index;

    logic                       is_err;
    logic                       is_oor;
    logic                       is_near;
    logic                       is_far;

    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = pac_pkg::reg_index_t'(paddr[pac_pkg::ADDR_W-1:2]);
    assign pready    = 1'b1;

    always_comb
    begin
        unique case (cfg_index)
            pac_pkg::REG_NEAR_THRESHOLD: prdata = {16'd0, near_thr_reg};
            pac_pkg::REG_FALL_LOW:       prdata = {16'd0, fall_low_reg};
            pac_pkg::REG_MAX_RANGE:      prdata = {16'd0, max_range_reg};
            pac_pkg::REG_QUIET_PERIOD:   prdata = quiet_reg;
            pac_pkg::REG_DWELL_PERIOD:   prdata = dwell_reg;
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_thr_reg  <= pac_pkg::NEAR_THRESHOLD_RST;
            fall_low_reg  <= pac_pkg::FALL_LOW_RST;
            max_range_reg <= pac_pkg::MAX_RANGE_RST;
            quiet_reg     <= pac_pkg::QUIET_PERIOD_RST;
            dwell_reg     <= pac_pkg::DWELL_PERIOD_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                pac_pkg::REG_NEAR_THRESHOLD: near_thr_reg  <= pwdata[pac_pkg::DIST_W-1:0];
                pac_pkg::REG_FALL_LOW:       fall_low_reg  <= pwdata[pac_pkg::DIST_W-1:0];
                pac_pkg::REG_MAX_RANGE:      max_range_reg <= pwdata[pac_pkg::DIST_W-1:0];
                pac_pkg::REG_QUIET_PERIOD:   quiet_reg     <= pwdata;
                pac_pkg::REG_DWELL_PERIOD:   dwell_reg     <= pwdata;
                default:                     ;
            endcase
        end
    end

    // The result register moves when it is empty or its transfer completes.
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            s1_dist_reg <= distance_mm;
            s1_now_reg  <= now_ticks;
            s1_hold_reg <= emergency_hold;
        end
    end

    assign is_err  = (s1_dist_reg == pac_pkg::READ_ERROR_CODE);
    assign is_oor  = (s1_dist_reg > max_range_reg);
    assign is_near = (s1_dist_reg < near_thr_reg);
    assign is_far  = (s1_dist_reg > near_thr_reg);

    always_comb
    begin
        prev_dist_next  = prev_dist_reg;
        connected_next  = connected_reg;
        last_range_next = last_range_reg;
        near_start_next = near_start_reg;
        obj_near_next   = obj_near_reg;
        dwell_done_next = dwell_done_reg;
        last_near_next  = last_near_reg;
        last_fall_next  = last_fall_reg;

        status_next = pac_pkg::STATUS_VALID;
        vdist_next  = '0;
        disc_next   = 1'b0;
        reco_next   = 1'b0;
        range_next  = 1'b0;
        near_next   = 1'b0;
        dwell_next  = 1'b0;
        fall_next   = 1'b0;

        priority if (s1_hold_reg)
        begin
            status_next = pac_pkg::STATUS_HELD;
        end
        else if (is_err)
        begin
            // A read error is classified before the range test.
            status_next    = pac_pkg::STATUS_READ_ERR;
            disc_next      = connected_reg;
            connected_next = 1'b0;
        end
        else if (is_oor)
        begin
            status_next = pac_pkg::STATUS_OUT_RANGE;
            if (pac_pkg::elapsed(s1_now_reg, last_range_reg, quiet_reg))
            begin
                range_next      = 1'b1;
                last_range_next = s1_now_reg;
            end
        end
        else
        begin
            vdist_next     = s1_dist_reg;
            reco_next      = !connected_reg;
            connected_next = 1'b1;

            if (is_near && pac_pkg::elapsed(s1_now_reg, last_near_reg, quiet_reg))
            begin
                near_next      = 1'b1;
                last_near_next = s1_now_reg;
            end

            if (is_near)
            begin
                if (!obj_near_reg)
                begin
                    near_start_next = s1_now_reg;
                    obj_near_next   = 1'b1;
                    dwell_done_next = 1'b0;
                end
                else if (!dwell_done_reg &&
                         pac_pkg::elapsed(s1_now_reg, near_start_reg, dwell_reg))
                begin
                    dwell_next      = 1'b1;
                    dwell_done_next = 1'b1;
                end
            end
            else
            begin
                obj_near_next   = 1'b0;
                dwell_done_next = 1'b0;
            end

            if (is_far && (prev_dist_reg < fall_low_reg) &&
                pac_pkg::elapsed(s1_now_reg, last_fall_reg, quiet_reg))
            begin
                fall_next      = 1'b1;
                last_fall_next = s1_now_reg;
            end

            prev_dist_next = s1_dist_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_dist_reg  <= '0;
            connected_reg  <= 1'b1;
            last_range_reg <= '0;
            near_start_reg <= '0;
            obj_near_reg   <= 1'b0;
            dwell_done_reg <= 1'b0;
            last_near_reg  <= '0;
            last_fall_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                prev_dist_reg  <= prev_dist_next;
                connected_reg  <= connected_next;
                last_range_reg <= last_range_next;
                near_start_reg <= near_start_next;
                obj_near_reg   <= obj_near_next;
                dwell_done_reg <= dwell_done_next;
                last_near_reg  <= last_near_next;
                last_fall_reg  <= last_fall_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            status_reg  <= status_next;
            vdist_reg   <= vdist_next;
            disc_reg    <= disc_next;
            reco_reg    <= reco_next;
            range_reg   <= range_next;
            near_reg    <= near_next;
            dwell_reg_o <= dwell_next;
            fall_reg    <= fall_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign sample_status    = status_reg;
    assign valid_distance   = vdist_reg;
    assign disconnect_event = disc_reg;
    assign reconnect_event  = reco_reg;
    assign range_report     = range_reg;
    assign near_alert       = near_reg;
    assign dwell_alert      = dwell_reg_o;
    assign fall_alert       = fall_reg;

    // A sample cannot both drop and restore the connection.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(disconnect_event && reconnect_event))
        else $error("disconnect and reconnect in one result");

    // Proximity alerts and a passed-on distance belong to valid samples only.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && sample_status != pac_pkg::STATUS_VALID) |->
        (valid_distance == '0 && !near_alert && !dwell_alert && !fall_alert))
        else $error("proximity output on a sample that is not valid");

    // A fall needs a far sample, while near and dwell need a near one.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(fall_alert && (near_alert || dwell_alert)))
        else $error("fall alert together with a near or dwell alert");

    // The input side only stalls when a sample waits in the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with an empty input register");

    // A stalled result leaves the tracking state untouched.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(connected_reg) && $stable(prev_dist_reg))
        else $error("state changed while the result was stalled");

endmodule

[tb/tb_proximity_alert_classifier.sv]
// Self-checking testbench for the proximity alert classifier with a built-in predictor.
module tb_proximity_alert_classifier;

    // Register indices past the last register; writes there must be ignored.
    localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [2:0] REG_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [pac_pkg::DIST_W-1:0] distance;
        logic [pac_pkg::TICK_W-1:0] ticks;
        logic                       hold;
    } sample_t;

    typedef struct packed {
        pac_pkg::status_t           status;
        logic [pac_pkg::DIST_W-1:0] vdist;
        logic                       disconnect;
        logic                       reconnect;
        logic                       range_rep;
        logic                       near;
        logic                       dwell;
        logic                       fall;
    } outcome_t;

    typedef enum {
        KIND_NEAR, KIND_LOW, KIND_MID, KIND_FAR, KIND_EDGE, KIND_ERROR, KIND_ANY
    } distance_kind_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [pac_pkg::DIST_W-1:0] distance_mm = '0;
    logic [pac_pkg::TICK_W-1:0] now_ticks = '0;
    logic                       emergency_hold = 1'b0;

    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [1:0]                 sample_status;
    logic [pac_pkg::DIST_W-1:0] valid_distance;
    logic                       disconnect_event;
    logic                       reconnect_event;
    logic                       range_report;
    logic                       near_alert;
    logic                       dwell_alert;
    logic                       fall_alert;

    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [pac_pkg::ADDR_W-1:0] paddr = '0;
    logic [pac_pkg::DATA_W-1:0] pwdata = '0;
    logic [pac_pkg::DATA_W-1:0] prdata;
    logic                       pready;

    sample_t  sample_queue[$];
    outcome_t expected_results[$];
    int unsigned mismatch_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    logic [pac_pkg::TICK_W-1:0] tick_now = '0;
    distance_kind_t distance_kind = KIND_MID;

    // Mirror of the configuration registers.
    logic [pac_pkg::DIST_W-1:0] cfg_near_thr  = pac_pkg::NEAR_THRESHOLD_RST;
    logic [pac_pkg::DIST_W-1:0] cfg_fall_low  = pac_pkg::FALL_LOW_RST;
    logic [pac_pkg::DIST_W-1:0] cfg_max_range = pac_pkg::MAX_RANGE_RST;
    logic [pac_pkg::TICK_W-1:0] cfg_quiet     = pac_pkg::QUIET_PERIOD_RST;
    logic [pac_pkg::TICK_W-1:0] cfg_dwell     = pac_pkg::DWELL_PERIOD_RST;

    // Tracking state of the predictor.
    logic [pac_pkg::DIST_W-1:0] m_prev_dist   = '0;
    logic                       m_connected   = 1'b1;
    logic [pac_pkg::TICK_W-1:0] m_range_mark  = '0;
    logic [pac_pkg::TICK_W-1:0] m_near_since  = '0;
    logic                       m_is_near     = 1'b0;
    logic                       m_dwell_fired = 1'b0;
    logic [pac_pkg::TICK_W-1:0] m_near_mark   = '0;
    logic [pac_pkg::TICK_W-1:0] m_fall_mark   = '0;

    proximity_alert_classifier u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .distance_mm      (distance_mm),
        .now_ticks        (now_ticks),
        .emergency_hold   (emergency_hold),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .sample_status    (sample_status),
        .valid_distance   (valid_distance),
        .disconnect_event (disconnect_event),
        .reconnect_event  (reconnect_event),
        .range_report     (range_report),
        .near_alert       (near_alert),
        .dwell_alert      (dwell_alert),
        .fall_alert       (fall_alert),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Works out the result of one accepted sample and advances the tracking state.
    function automatic void classify_sample(input sample_t s);
        outcome_t r;
        logic [pac_pkg::TICK_W-1:0] since_range;
        logic [pac_pkg::TICK_W-1:0] since_near;
        logic [pac_pkg::TICK_W-1:0] since_fall;
        logic [pac_pkg::TICK_W-1:0] since_start;
        r = '0;
        since_range = s.ticks - m_range_mark;
        since_near  = s.ticks - m_near_mark;
        since_fall  = s.ticks - m_fall_mark;
        since_start = s.ticks - m_near_since;
        if (s.hold)
        begin
            r.status = pac_pkg::STATUS_HELD;
        end
        else if (s.distance == pac_pkg::READ_ERROR_CODE)
        begin
            r.status = pac_pkg::STATUS_READ_ERR;
            if (m_connected)
            begin
                r.disconnect = 1'b1;
                m_connected = 1'b0;
            end
        end
        else if (s.distance > cfg_max_range)
        begin
            r.status = pac_pkg::STATUS_OUT_RANGE;
            if (since_range >= cfg_quiet)
            begin
                r.range_rep = 1'b1;
                m_range_mark = s.ticks;
            end
        end
        else
        begin
            r.status = pac_pkg::STATUS_VALID;
            r.vdist = s.distance;
            if (!m_connected)
            begin
                r.reconnect = 1'b1;
                m_connected = 1'b1;
            end
            if (s.distance < cfg_near_thr)
            begin
                if (since_near >= cfg_quiet)
                begin
                    r.near = 1'b1;
                    m_near_mark = s.ticks;
                end
                if (!m_is_near)
                begin
                    m_near_since = s.ticks;
                    m_is_near = 1'b1;
                    m_dwell_fired = 1'b0;
                end
                else if (!m_dwell_fired && since_start >= cfg_dwell)
                begin
                    r.dwell = 1'b1;
                    m_dwell_fired = 1'b1;
                end
            end
            else
            begin
                m_is_near = 1'b0;
                m_dwell_fired = 1'b0;
            end
            if (s.distance > cfg_near_thr && m_prev_dist < cfg_fall_low &&
                since_fall >= cfg_quiet)
            begin
                r.fall = 1'b1;
                m_fall_mark = s.ticks;
            end
            m_prev_dist = s.distance;
        end
        expected_results.push_back(r);
    endfunction

    function automatic void check_field(input string field, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endfunction

    // Sample driver: a new transfer is offered only once the previous one has been taken.
    always @(posedge clk or negedge rst_n)
    begin : drive
        sample_t next_sample;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                classify_sample(sample_t'({distance_mm, now_ticks, emergency_hold}));
            end
            if (!in_valid || !in_stall)
            begin
                if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_sample = sample_queue.pop_front();
                    in_valid <= 1'b1;
                    distance_mm <= next_sample.distance;
                    now_ticks <= next_sample.ticks;
                    emergency_hold <= next_sample.hold;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge clk or negedge rst_n)
    begin : watch
        outcome_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result with no transfer outstanding, status %0d",
                             $time, sample_status);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("sample_status", 16'(want.status), 16'(sample_status));
                    check_field("valid_distance", want.vdist, valid_distance);
                    check_field("disconnect_event", 16'(want.disconnect),
                                16'(disconnect_event));
                    check_field("reconnect_event", 16'(want.reconnect), 16'(reconnect_event));
                    check_field("range_report", 16'(want.range_rep), 16'(range_report));
                    check_field("near_alert", 16'(want.near), 16'(near_alert));
                    check_field("dwell_alert", 16'(want.dwell), 16'(dwell_alert));
                    check_field("fall_alert", 16'(want.fall), 16'(fall_alert));
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic write_register(input logic [2:0] idx,
                                  input logic [pac_pkg::DATA_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            pac_pkg::REG_NEAR_THRESHOLD: cfg_near_thr = value[pac_pkg::DIST_W-1:0];
            pac_pkg::REG_FALL_LOW:       cfg_fall_low = value[pac_pkg::DIST_W-1:0];
            pac_pkg::REG_MAX_RANGE:      cfg_max_range = value[pac_pkg::DIST_W-1:0];
            pac_pkg::REG_QUIET_PERIOD:   cfg_quiet = value;
            pac_pkg::REG_DWELL_PERIOD:   cfg_dwell = value;
            default: ;
        endcase
    endtask

    task automatic push_sample(input logic [pac_pkg::DIST_W-1:0] distance,
                               input logic [pac_pkg::TICK_W-1:0] ticks,
                               input logic hold);
        sample_t s;
        s.distance = distance;
        s.ticks = ticks;
        s.hold = hold;
        sample_queue.push_back(s);
        tick_now = ticks;
    endtask

    // Distances come in runs of one kind so that near spells and fall patterns build up.
    function automatic logic [pac_pkg::DIST_W-1:0] pick_distance();
        int unsigned r;
        int unsigned lo;
        if ($urandom_range(99) < 30)
        begin
            r = $urandom_range(99);
            if (r < 28)      distance_kind = KIND_NEAR;
            else if (r < 43) distance_kind = KIND_LOW;
            else if (r < 68) distance_kind = KIND_MID;
            else if (r < 80) distance_kind = KIND_FAR;
            else if (r < 90) distance_kind = KIND_EDGE;
            else if (r < 95) distance_kind = KIND_ERROR;
            else             distance_kind = KIND_ANY;
        end
        case (distance_kind)
            KIND_NEAR:
                if (cfg_near_thr != 0) return 16'($urandom_range(0, cfg_near_thr - 1));
            KIND_LOW:
                if (cfg_fall_low != 0) return 16'($urandom_range(0, cfg_fall_low - 1));
            KIND_MID:
                return 16'($urandom_range(cfg_near_thr, cfg_max_range));
            KIND_FAR:
            begin
                lo = cfg_max_range + 1;
                if (lo < 65535) return 16'($urandom_range(lo, 65534));
            end
            KIND_EDGE:
            begin
                r = $urandom_range(6);
                case (r)
                    0: return cfg_near_thr - 16'd1;
                    1: return cfg_near_thr;
                    2: return cfg_near_thr + 16'd1;
                    3: return cfg_fall_low - 16'd1;
                    4: return cfg_fall_low;
                    5: return cfg_max_range;
                    default: return cfg_max_range + 16'd1;
                endcase
            end
            KIND_ERROR:
                return pac_pkg::READ_ERROR_CODE;
            default: ;
        endcase
        return 16'($urandom);
    endfunction

    // Tick advance: mostly small, often on the scale of the periods, sometimes a wild jump.
    function automatic logic [pac_pkg::TICK_W-1:0] pick_step();
        int unsigned r;
        logic [pac_pkg::TICK_W-1:0] period;
        r = $urandom_range(99);
        period = $urandom_range(1) ? cfg_quiet : cfg_dwell;
        if (r < 45) return $urandom_range(0, 64);
        if (r < 85) return $urandom_range(0, (period >> 2) + 1);
        if (r < 91) return period;
        if (r < 96) return period - 1;
        return $urandom;
    endfunction

    task automatic queue_random_samples(input int unsigned count);
        logic [pac_pkg::DIST_W-1:0] distance;
        repeat (count)
        begin
            distance = pick_distance();
            push_sample(distance, tick_now + pick_step(), $urandom_range(99) < 6);
        end
    endtask

    // Returns once every transfer has been sent and every result has come back.
    task automatic wait_for_drain();
        do
            @(negedge clk);
        while (sample_queue.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed samples under the reset configuration.
        send_idle_pct = 13;
        recv_idle_pct = 79;
        push_sample(16'd0, 32'd0, 1'b1);
        push_sample(pac_pkg::READ_ERROR_CODE, 32'd0, 1'b0);
        push_sample(pac_pkg::READ_ERROR_CODE, 32'd5, 1'b0);
        push_sample(16'd2001, 32'd10, 1'b0);
        push_sample(16'd1000, 32'd6000, 1'b0);
        push_sample(16'd50, 32'd7000, 1'b0);
        push_sample(16'd50, 32'd11999, 1'b0);
        push_sample(16'd50, 32'd12000, 1'b0);
        push_sample(16'd200, 32'd12001, 1'b0);
        push_sample(16'd2000, 32'd20000, 1'b0);
        push_sample(16'd9000, 32'd20001, 1'b0);
        push_sample(16'd9000, 32'd20002, 1'b0);
        push_sample(16'd65534, 32'd30000, 1'b0);
        push_sample(16'd0, 32'd30001, 1'b0);
        push_sample(pac_pkg::READ_ERROR_CODE, 32'hFFFF_FFFF, 1'b1);
        push_sample(16'd300, 32'd36000, 1'b0);
        push_sample(16'd99, 32'd36001, 1'b0);
        push_sample(16'd201, 32'd36002, 1'b0);
        push_sample(16'd10, 32'hFFFF_FF00, 1'b0);
        push_sample(16'd10, 32'h0000_1300, 1'b0);
        push_sample(pac_pkg::READ_ERROR_CODE, 32'hFFFF_FFFF, 1'b0);
        push_sample(16'd199, 32'h0000_2000, 1'b0);
        wait_for_drain();

        write_register(pac_pkg::REG_NEAR_THRESHOLD, 32'd1500);
        write_register(pac_pkg::REG_FALL_LOW, 32'd800);
        write_register(pac_pkg::REG_MAX_RANGE, 32'd3000);
        write_register(pac_pkg::REG_QUIET_PERIOD, 32'd300);
        write_register(pac_pkg::REG_DWELL_PERIOD, 32'd500);
        queue_random_samples(250);
        wait_for_drain();

        // Upper extremes; a read error must win even with the full range enabled.
        send_idle_pct = 79;
        recv_idle_pct = 13;
        write_register(pac_pkg::REG_NEAR_THRESHOLD, 32'd65535);
        write_register(pac_pkg::REG_FALL_LOW, 32'd65535);
        write_register(pac_pkg::REG_MAX_RANGE, 32'd65535);
        write_register(pac_pkg::REG_QUIET_PERIOD, 32'd0);
        write_register(pac_pkg::REG_DWELL_PERIOD, 32'd0);
        push_sample(pac_pkg::READ_ERROR_CODE, tick_now, 1'b0);
        push_sample(16'd65534, tick_now, 1'b0);
        push_sample(16'd0, tick_now, 1'b0);
        push_sample(16'd0, tick_now, 1'b0);
        queue_random_samples(125);
        wait_for_drain();

        // Lower extremes, with writes to unused addresses that must change nothing.
        write_register(REG_SPARE_FIRST, 32'hFFFF_FFFF);
        write_register(REG_SPARE_LAST, 32'h0000_0001);
        write_register(pac_pkg::REG_NEAR_THRESHOLD, 32'd0);
        write_register(pac_pkg::REG_FALL_LOW, 32'd0);
        write_register(pac_pkg::REG_MAX_RANGE, 32'd0);
        write_register(pac_pkg::REG_QUIET_PERIOD, 32'hFFFF_FFFF);
        write_register(pac_pkg::REG_DWELL_PERIOD, 32'hFFFF_FFFF);
        queue_random_samples(125);
        wait_for_drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_register(pac_pkg::REG_NEAR_THRESHOLD, 32'd400);
        write_register(pac_pkg::REG_FALL_LOW, 32'd150);
        write_register(pac_pkg::REG_MAX_RANGE, 32'd1200);
        write_register(pac_pkg::REG_QUIET_PERIOD, 32'd40);
        write_register(pac_pkg::REG_DWELL_PERIOD, 32'd60);
        queue_random_samples(125);
        wait_for_drain();
        queue_random_samples(125);
        wait_for_drain();

        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("tb_proximity_alert_classifier: done, clean");
        end
        else
        begin
            $display("tb_proximity_alert_classifier: done, errors");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb_proximity_alert_classifier: done, errors");
        $finish;
    end

endmodule

[proximity_alert_classifier.f]
rtl/pac_pkg.sv
rtl/proximity_alert_classifier.sv
tb/tb_proximity_alert_classifier.sv
